@@ rtl/vva_pkg.sv @@
// shared types, codes and default sizes for the velocity verlet atom update block
`timescale 1ns / 1ps

package vva_pkg;

    // default sizes
    localparam int unsigned MAX_ATOMS_DEF   = 65536;
    localparam int unsigned COORD_WIDTH_DEF = 32;

    // data widths fixed by the interface
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned STEP_W  = 3;

    // operation codes
    localparam logic OP_DRIFT = 1'b0;
    localparam logic OP_KICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Z      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 3'd7;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // register reset values
    localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;
    localparam logic [30:0]              LIMIT_RESET = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                     op;
        logic [1:0]               axis;
        logic                     clear_count;
        logic                     unfrozen;
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        logic signed [DATA_W-1:0] force_req;
        logic signed [DATA_W-1:0] new_force;
        logic signed [DATA_W-1:0] step_over_mass;
    } vva_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] position_out;
        logic signed [DATA_W-1:0] velocity_out;
        logic signed [DATA_W-1:0] force_out;
        logic                     atom_limited;
        logic [CNT_W-1:0]         limited_count;
    } vva_out_t;

endpackage

@@ rtl/vva_stream_if.sv @@
// valid/ready stream channel carrying one word per handshake
`timescale 1ns / 1ps

interface vva_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/velocity_verlet_atom_update.sv @@
// velocity verlet update of one atom coordinate with a shared multiplier sequencer
`timescale 1ns / 1ps

// usage
// - req (sink) takes one word per atom axis: op selects drift (position update)
//   or kick (velocity update); all values are signed q16.16
// - rsp (source) returns one word per request with position, velocity, force,
//   the current atom's limited flag and the limited-atom count
// - cfg_we/cfg_index/cfg_data write the step, per-axis scales and limits and the
//   limit enable; write only while no request is in flight
// - every word runs five sequencer steps around one shared 32x32 multiplier;
//   the sums, clamps and saturations are small adder stages beside it
// - a new request is taken while idle or in the cycle the previous result is
//   loaded into the output register; no word is taken while one is in flight
// - if rsp stalls, the finished result waits in the sequencer's last step and
//   req stays low until the output register frees up; nothing is dropped
// - reset: registers take their default values, the atom flag and the count
//   clear, the output register empties and the block is ready at once
// - drift words on axis z (or the unused code 3) close the atom: the flag is
//   counted (saturating) and cleared
module velocity_verlet_atom_update
    import vva_pkg::*;
#(
    parameter int unsigned MAX_ATOMS   = MAX_ATOMS_DEF,
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    vva_stream_if.sink           req,
    vva_stream_if.source         rsp
);

    // saturation range and counter cap
    localparam int unsigned EFF_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (EFF_W - 1)) - 48'sd1;
    localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;
    localparam logic [CNT_W-1:0] CNT_CAP =
        CNT_W'((MAX_ATOMS < 131071) ? MAX_ATOMS : 131071);
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    // clamp to the coordinate range
    function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [47:0] v);
        logic signed [47:0] r;
        begin
            r = v;
            if (v > SAT_HI)
            begin
                r = SAT_HI;
            end
            else if (v < SAT_LO)
            begin
                r = SAT_LO;
            end
            return r[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [47:0] sx(input logic signed [DATA_W-1:0] v);
        return {{16{v[DATA_W-1]}}, v};
    endfunction

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    vva_in_t                  item_reg, item_next;
    logic signed [DATA_W-1:0] t0_reg, t0_next;
    logic signed [DATA_W-1:0] t1_reg, t1_next;
    logic                     flag_reg, flag_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    vva_out_t                 out_reg, out_next;

    // configuration registers
    logic [30:0]              time_step_reg, time_step_next;
    logic signed [DATA_W-1:0] scale_x_reg, scale_x_next;
    logic signed [DATA_W-1:0] scale_y_reg, scale_y_next;
    logic signed [DATA_W-1:0] scale_z_reg, scale_z_next;
    logic [30:0]              limit_x_reg, limit_x_next;
    logic [30:0]              limit_y_reg, limit_y_next;
    logic [30:0]              limit_z_reg, limit_z_next;
    logic                     limit_enable_reg, limit_enable_next;

    // shared multiplier
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [2*DATA_W-1:0] mul_p;
    logic signed [DATA_W-1:0]   mul_q;

    logic signed [DATA_W-1:0] dt_s, half_m, scl, off;
    logic [30:0]              lim;
    logic signed [47:0]       lim_w, off_w;
    logic                     finish, accept;

    assign dt_s   = {1'b0, time_step_reg};
    assign half_m = item_reg.step_over_mass >>> 1;
    assign lim    = (item_reg.axis == AXIS_X) ? limit_x_reg :
                    (item_reg.axis == AXIS_Y) ? limit_y_reg : limit_z_reg;
    assign scl    = (item_reg.axis == AXIS_X) ? scale_x_reg :
                    (item_reg.axis == AXIS_Y) ? scale_y_reg : scale_z_reg;
    assign lim_w  = {17'd0, lim};

    // result can leave when the output register is free or being emptied
    assign finish = (state_reg == S_RUN) && (step_reg == STEP_LAST)
                    && (!out_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE) || finish;
    assign accept    = req.valid && req.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // operand select for the multiplier
    always_comb
    begin
        mul_a = dt_s;
        mul_b = item_reg.velocity;
        case ({item_reg.op, step_reg})
            {OP_DRIFT, 3'd1}:
            begin
                mul_a = dt_s;
                mul_b = item_reg.step_over_mass;
            end
            {OP_DRIFT, 3'd2}:
            begin
                mul_a = t1_reg;
                mul_b = item_reg.force_req;
            end
            {OP_KICK, 3'd1}:
            begin
                mul_a = half_m;
                mul_b = t0_reg;
            end
            {OP_KICK, 3'd3}:
            begin
                mul_a = t0_reg;
                mul_b = scl;
            end
            default:
            begin
                mul_a = dt_s;
                mul_b = item_reg.velocity;
            end
        endcase
    end

    // product floors at the binary point, then saturates
    assign mul_p = mul_a * mul_b;
    assign mul_q = sat_w(mul_p[2*DATA_W-1:16]);

    // drift offset and its clamp
    assign off_w = sx(sat_w(sx(t0_reg) + sx(t1_reg)));

    always_comb
    begin
        off = off_w[DATA_W-1:0];
        if (limit_enable_reg && (off_w > lim_w))
        begin
            off = {1'b0, lim};
        end
        else if (limit_enable_reg && (off_w < -lim_w))
        begin
            off = -{1'b0, lim};
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        item_next         = item_reg;
        t0_next           = t0_reg;
        t1_next           = t1_reg;
        flag_next         = flag_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_next          = out_reg;
        time_step_next    = time_step_reg;
        scale_x_next      = scale_x_reg;
        scale_y_next      = scale_y_reg;
        scale_z_next      = scale_z_reg;
        limit_x_next      = limit_x_reg;
        limit_y_next      = limit_y_reg;
        limit_z_next      = limit_z_reg;
        limit_enable_next = limit_enable_reg;

        // config writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIME_STEP:    time_step_next    = cfg_data[30:0];
                CFG_SCALE_X:      scale_x_next      = cfg_data;
                CFG_SCALE_Y:      scale_y_next      = cfg_data;
                CFG_SCALE_Z:      scale_z_next      = cfg_data;
                CFG_LIMIT_X:      limit_x_next      = cfg_data[30:0];
                CFG_LIMIT_Y:      limit_y_next      = cfg_data[30:0];
                CFG_LIMIT_Z:      limit_z_next      = cfg_data[30:0];
                CFG_LIMIT_ENABLE: limit_enable_next = cfg_data[0];
                default:          limit_enable_next = limit_enable_reg;
            endcase
        end

        // sequencer steps
        if (state_reg == S_RUN)
        begin
            if (item_reg.op == OP_DRIFT)
            begin
                unique case (step_reg)
                    3'd0: t0_next = mul_q;
                    3'd1: t1_next = mul_q;
                    3'd2: t1_next = mul_q;
                    3'd3:
                    begin
                        t0_next = off;
                        if (limit_enable_reg && (off != off_w[DATA_W-1:0]))
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (finish)
                        begin
                            out_next.position_out = item_reg.unfrozen ?
                                sat_w(sx(item_reg.position) + sx(t0_reg)) :
                                item_reg.position;
                            out_next.velocity_out = item_reg.velocity;
                            out_next.force_out    = item_reg.force_req;
                            out_next.atom_limited = flag_reg;
                            // axis z and the spare code close the atom
                            if (item_reg.axis[1])
                            begin
                                if (flag_reg && (count_reg < CNT_CAP))
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                                flag_next = 1'b0;
                            end
                            out_next.limited_count = count_next;
                        end
                    end
                endcase
            end
            else
            begin
                unique case (step_reg)
                    3'd0: t0_next = sat_w(sx(item_reg.force_req) + sx(item_reg.new_force));
                    3'd1: t0_next = mul_q;
                    3'd2: t0_next = sat_w(sx(item_reg.velocity) + sx(t0_reg));
                    3'd3: t0_next = mul_q;
                    default:
                    begin
                        if (finish)
                        begin
                            out_next.position_out  = item_reg.position;
                            out_next.velocity_out  = item_reg.unfrozen ?
                                                     t0_reg : item_reg.velocity;
                            out_next.force_out     = item_reg.unfrozen ?
                                                     item_reg.new_force : item_reg.force_req;
                            out_next.atom_limited  = flag_reg;
                            out_next.limited_count = count_reg;
                        end
                    end
                endcase
            end

            if (step_reg != STEP_LAST)
            begin
                step_next = step_reg + 1'b1;
            end
            else if (finish)
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
        end

        // new word: the count clear applies before its own work
        if (accept)
        begin
            item_next  = req.payload;
            state_next = S_RUN;
            step_next  = '0;
            if (req.payload.clear_count)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            item_reg         <= '0;
            t0_reg           <= '0;
            t1_reg           <= '0;
            flag_reg         <= 1'b0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
            time_step_reg    <= '0;
            scale_x_reg      <= SCALE_RESET;
            scale_y_reg      <= SCALE_RESET;
            scale_z_reg      <= SCALE_RESET;
            limit_x_reg      <= LIMIT_RESET;
            limit_y_reg      <= LIMIT_RESET;
            limit_z_reg      <= LIMIT_RESET;
            limit_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            item_reg         <= item_next;
            t0_reg           <= t0_next;
            t1_reg           <= t1_next;
            flag_reg         <= flag_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
            out_reg          <= out_next;
            time_step_reg    <= time_step_next;
            scale_x_reg      <= scale_x_next;
            scale_y_reg      <= scale_y_next;
            scale_z_reg      <= scale_z_next;
            limit_x_reg      <= limit_x_next;
            limit_y_reg      <= limit_y_next;
            limit_z_reg      <= limit_z_next;
            limit_enable_reg <= limit_enable_next;
        end
    end

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for the velocity verlet atom update block
`timescale 1ns / 1ps

module tb_top;
    import vva_pkg::*;

    // saturation bounds of a q16.16 word, held in 64 bits for exact products
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint COUNT_CAP = (MAX_ATOMS_DEF < 131071) ? MAX_ATOMS_DEF : 131071;

    // axis codes the package leaves out; code 3 behaves like z
    localparam logic [1:0] AXIS_Z      = 2'd2;
    localparam logic [1:0] AXIS_UNUSED = 2'd3;

    localparam int LATENCY     = 5;
    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 98;
    localparam int REPORT_MAX  = 10;

    // one row of the directed table: either a register write or a request word,
    // the latter with a hand-typed result where it is obvious
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        vva_in_t              word;
        bit                   typed;
        vva_out_t             known;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    vva_stream_if #(.payload_t(vva_in_t))  req_if ();
    vva_stream_if #(.payload_t(vva_out_t)) rsp_if ();

    velocity_verlet_atom_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // shadow copy of the register file, reset values
    logic [30:0]        step_q  = '0;
    logic signed [31:0] scale_q [3] = '{SCALE_RESET, SCALE_RESET, SCALE_RESET};
    logic [30:0]        limit_q [3] = '{LIMIT_RESET, LIMIT_RESET, LIMIT_RESET};
    bit                 limit_on = 1'b0;

    // shadow of the block's atom state
    bit                 atom_flag   = 1'b0;
    int unsigned        limited_cnt = 0;

    vva_out_t           predicted_updates [$];
    stim_row_t          stim_tab [$];
    int unsigned        mismatch_count = 0;
    int                 burst_left;

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset held low from the start, released once
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("[velocity_verlet_atom_update] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic longint clip_q(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // exact product, low 16 bits dropped (floor), then saturated
    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        return clip_q(p >>> 16);
    endfunction

    // the register write as the block sees it; 31-bit registers drop bit 31
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] val);
        case (idx)
            CFG_TIME_STEP:    step_q     = val[30:0];
            CFG_SCALE_X:      scale_q[0] = val;
            CFG_SCALE_Y:      scale_q[1] = val;
            CFG_SCALE_Z:      scale_q[2] = val;
            CFG_LIMIT_X:      limit_q[0] = val[30:0];
            CFG_LIMIT_Y:      limit_q[1] = val[30:0];
            CFG_LIMIT_Z:      limit_q[2] = val[30:0];
            CFG_LIMIT_ENABLE: limit_on   = val[0];
            default:          ;
        endcase
    endfunction

    // works out the result of one accepted word and advances the atom state
    function automatic vva_out_t predict_update(input vva_in_t w);
        vva_out_t    r;
        int unsigned a;
        longint      dt, pos, vel, frc, fnew, m, off, lim, sum, v2;
        a    = (w.axis == AXIS_X) ? 0 : (w.axis == AXIS_Y) ? 1 : 2;
        pos  = longint'($signed(w.position));
        vel  = longint'($signed(w.velocity));
        frc  = longint'($signed(w.force_req));
        fnew = longint'($signed(w.new_force));
        m    = longint'($signed(w.step_over_mass));
        r.position_out = w.position;
        r.velocity_out = w.velocity;
        r.force_out    = w.force_req;

        // count clear happens ahead of the word, in either mode
        if (w.clear_count)
            limited_cnt = 0;

        if (w.op == OP_DRIFT)
        begin
            dt  = longint'(step_q);
            off = clip_q(fx_mul(dt, vel) + fx_mul(fx_mul(dt, m), frc));
            lim = longint'(limit_q[a]);
            // clamping flags the atom whether it is frozen or not
            if (limit_on)
            begin
                if (off > lim)
                begin
                    off = lim;
                    atom_flag = 1'b1;
                end
                else if (off < -lim)
                begin
                    off = -lim;
                    atom_flag = 1'b1;
                end
            end
            if (w.unfrozen)
                r.position_out = 32'(clip_q(pos + off));
            r.atom_limited = atom_flag;
            // z (or the unused code) closes the atom: count, then clear the flag
            if (w.axis != AXIS_X && w.axis != AXIS_Y)
            begin
                if (atom_flag && limited_cnt < COUNT_CAP)
                    limited_cnt++;
                atom_flag = 1'b0;
            end
        end
        else
        begin
            if (w.unfrozen)
            begin
                sum = clip_q(frc + fnew);
                v2  = clip_q(vel + fx_mul(m >>> 1, sum));
                r.velocity_out = 32'(fx_mul(v2, longint'(scale_q[a])));
                r.force_out    = w.new_force;
            end
            r.atom_limited = atom_flag;
        end
        r.limited_count = CNT_W'(limited_cnt);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    function automatic stim_row_t word_row(input logic op_code, input logic [1:0] ax,
                                           input bit clr, input bit unf,
                                           input logic [31:0] pos, input logic [31:0] vel,
                                           input logic [31:0] frc, input logic [31:0] fnew,
                                           input logic [31:0] m);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed   = 1'b0;
        r.known   = '0;
        r.word.op             = op_code;
        r.word.axis           = ax;
        r.word.clear_count    = clr;
        r.word.unfrozen       = unf;
        r.word.position       = pos;
        r.word.velocity       = vel;
        r.word.force_req      = frc;
        r.word.new_force      = fnew;
        r.word.step_over_mass = m;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        stim_row_t r;
        r = word_row(OP_DRIFT, AXIS_X, 1'b0, 1'b0, '0, '0, '0, '0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t fixed_row(input stim_row_t r, input logic [31:0] pos,
                                            input logic [31:0] vel, input logic [31:0] frc,
                                            input bit flag, input logic [CNT_W-1:0] cnt);
        r.typed              = 1'b1;
        r.known.position_out  = pos;
        r.known.velocity_out  = vel;
        r.known.force_out     = frc;
        r.known.atom_limited  = flag;
        r.known.limited_count = cnt;
        return r;
    endfunction

    // operand mix: extremes, zero, full-range noise and values of every magnitude
    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return $urandom();
            default: return $signed($urandom()) >>> $urandom_range(4, 26);
        endcase
    endfunction

    // register value for a phase: phase 0 all high extremes, phase 1 low extremes
    // with limiting still on, the rest a random blend
    function automatic logic [CFG_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx,
                                                      input int ph);
        case (idx) inside
            CFG_TIME_STEP:
            begin
                if (ph == 0) return 32'h7FFF_FFFF;
                if (ph == 1) return 32'h0;
                case ($urandom_range(0, 3))
                    0:       return 32'h0001_0000;
                    1:       return $urandom();
                    default: return $urandom_range(1, 32'h0002_0000);
                endcase
            end
            CFG_SCALE_X, CFG_SCALE_Y, CFG_SCALE_Z:
            begin
                if (ph == 0) return 32'h7FFF_FFFF;
                if (ph == 1) return 32'h8000_0000;
                case ($urandom_range(0, 4))
                    0:       return 32'h0001_0000;
                    1:       return 32'hFFFF_0000;
                    2:       return 32'h0;
                    3:       return $urandom();
                    default: return $signed($urandom()) >>> 12;
                endcase
            end
            CFG_LIMIT_X, CFG_LIMIT_Y, CFG_LIMIT_Z:
            begin
                if (ph == 0) return 32'h7FFF_FFFF;
                if (ph == 1) return 32'h0;
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return $urandom();
                    default: return $urandom_range(0, 32'h0004_0000);
                endcase
            end
            default:
            begin
                // enable: upper data bits carry junk the block must ignore
                if (ph < 2) return 32'h1;
                return ($urandom() & 32'hFFFF_FFFE) | 32'($urandom_range(0, 3) != 0);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    // presents one word, waits for the handshake, then maybe opens a gap;
    // valid stays high between words of one burst
    task automatic send_word(input vva_in_t w, input bit typed, input vva_out_t known);
        vva_out_t pred;
        req_if.valid   <= 1'b1;
        req_if.payload <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pred = predict_update(w);
        predicted_updates.push_back(typed ? known : pred);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // drop valid and wait for every owed result, plus the pipeline depth
    task automatic settle_idle();
        req_if.valid <= 1'b0;
        while (predicted_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // one register write; the caller lowers the write enable after a run of these
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
    endtask

    // mostly whole atoms (x, y, z drift or kick with shared mass and frozen
    // state), the rest single words of any kind
    task automatic run_random(input int n_words);
        int          sent;
        int          kind;
        int          len;
        bit          unf;
        logic [31:0] m;
        logic [1:0]  ax;
        vva_in_t     w;
        sent = 0;
        while (sent < n_words)
        begin
            kind = $urandom_range(0, 19);
            unf  = ($urandom_range(0, 3) != 0);
            m    = rand_q();
            len  = (kind < 17) ? 3 : 1;
            for (int k = 0; k < len; k++)
            begin
                if (kind < 17)
                begin
                    w.op = (kind < 13) ? OP_DRIFT : OP_KICK;
                    ax = (k == 0) ? AXIS_X : (k == 1) ? AXIS_Y : AXIS_Z;
                    // now and then close the atom on the unused code
                    if (k == 2 && $urandom_range(0, 3) == 0)
                        ax = AXIS_UNUSED;
                    w.unfrozen       = unf;
                    w.step_over_mass = m;
                end
                else
                begin
                    w.op = $urandom_range(0, 1) ? OP_KICK : OP_DRIFT;
                    ax = 2'($urandom_range(0, 3));
                    w.unfrozen       = 1'($urandom_range(0, 1));
                    w.step_over_mass = rand_q();
                end
                w.axis        = ax;
                w.clear_count = ($urandom_range(0, 15) == 0);
                w.position    = rand_q();
                w.velocity    = rand_q();
                w.force_req   = rand_q();
                w.new_force   = rand_q();
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    task automatic check_word(input vva_out_t got);
        vva_out_t want;
        if (predicted_updates.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("unexpected word: pos %h vel %h frc %h flag %b cnt %0d",
                         got.position_out, got.velocity_out, got.force_out,
                         got.atom_limited, got.limited_count);
        end
        else
        begin
            want = predicted_updates.pop_front();
            if (got.position_out  !== want.position_out  ||
                got.velocity_out  !== want.velocity_out  ||
                got.force_out     !== want.force_out     ||
                got.atom_limited  !== want.atom_limited  ||
                got.limited_count !== want.limited_count)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("mismatch at %0t: exp pos %h vel %h frc %h flag %b cnt %0d",
                             $realtime, want.position_out, want.velocity_out,
                             want.force_out, want.atom_limited, want.limited_count);
                    $display("                 got pos %h vel %h frc %h flag %b cnt %0d",
                             got.position_out, got.velocity_out, got.force_out,
                             got.atom_limited, got.limited_count);
                end
            end
        end
    endtask

    // receiver: checks every accepted word, and stalls in a mode that a tick counter
    // redraws (always ready, a rotating pattern, or random draws)
    initial
    begin
        int unsigned tick;
        int          mode;
        logic [15:0] stall_pat;
        rsp_if.ready = 1'b0;
        tick         = 0;
        mode         = 0;
        stall_pat    = 16'b1101_1110_0111_1011;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                check_word(rsp_if.payload);
            if (tick % 48 == 0)
                mode = $urandom_range(0, 2);
            tick++;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            case (mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= stall_pat[0];
                default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        stim_row_t row;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        burst_left     = $urandom_range(1, 24);

        // registers at reset: zero step, unit scales, limiting off, so drift
        // leaves everything as it is
        stim_tab.push_back(fixed_row(word_row(OP_DRIFT, AXIS_X, 1'b0, 1'b1,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 17'd0));
        stim_tab.push_back(fixed_row(word_row(OP_DRIFT, AXIS_Z, 1'b1, 1'b1,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000),
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 17'd0));
        // kick with zero mass term and unit scale keeps the velocity, takes new force
        stim_tab.push_back(fixed_row(word_row(OP_KICK, AXIS_X, 1'b0, 1'b1,
            32'h1234_5678, 32'h0003_8000, 32'h0000_0007, 32'hFFFF_FFFB, 32'h0),
            32'h1234_5678, 32'h0003_8000, 32'hFFFF_FFFB, 1'b0, 17'd0));
        // frozen kick passes through
        stim_tab.push_back(fixed_row(word_row(OP_KICK, AXIS_Y, 1'b0, 1'b0,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 17'd0));
        // saturating kicks, unused axis code, odd negative mass halving
        stim_tab.push_back(word_row(OP_KICK, AXIS_Z, 1'b0, 1'b1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        stim_tab.push_back(word_row(OP_KICK, AXIS_UNUSED, 1'b0, 1'b1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        stim_tab.push_back(word_row(OP_KICK, AXIS_X, 1'b0, 1'b1,
            32'h0, 32'hFFFF_FFFD, 32'h0001_0001, 32'hFFFF_0000, 32'hFFFF_FFFF));

        // unit step, tight limits on x and y, limiting on
        stim_tab.push_back(reg_row(CFG_TIME_STEP, 32'h0001_0000));
        stim_tab.push_back(reg_row(CFG_LIMIT_X, 32'h0001_0000));
        stim_tab.push_back(reg_row(CFG_LIMIT_Y, 32'h0));
        stim_tab.push_back(reg_row(CFG_LIMIT_ENABLE, 32'h1));
        // positive clamp on x, frozen negative clamp on y, z closes the atom
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_X, 1'b0, 1'b1,
            32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h0));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_Y, 1'b0, 1'b0,
            32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_Z, 1'b0, 1'b1,
            32'h0001_0000, 32'h0000_1000, 32'h0, 32'h0, 32'h0));
        // kick reports the count and leaves it alone
        stim_tab.push_back(word_row(OP_KICK, AXIS_X, 1'b0, 1'b1,
            32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000));
        // a frozen atom is counted too, closed on the unused code
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_X, 1'b0, 1'b0,
            32'h0, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_UNUSED, 1'b0, 1'b0,
            32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        // clear on a clamped y drift: the flag survives the clear
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_Y, 1'b1, 1'b1,
            32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0002_0000));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_Z, 1'b0, 1'b1,
            32'h0, 32'h0, 32'h0, 32'h0, 32'h0));

        // limiting off, largest step: saturating drift, z still closes
        stim_tab.push_back(reg_row(CFG_LIMIT_ENABLE, 32'h0));
        stim_tab.push_back(reg_row(CFG_TIME_STEP, 32'h7FFF_FFFF));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_X, 1'b0, 1'b1,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
        stim_tab.push_back(word_row(OP_DRIFT, AXIS_Z, 1'b0, 1'b1,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF));
        // clear in kick mode
        stim_tab.push_back(word_row(OP_KICK, AXIS_Y, 1'b1, 1'b1,
            32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));

        wait (rst_n === 1'b1);
        @(posedge clk);

        // directed table
        foreach (stim_tab[i])
        begin
            row = stim_tab[i];
            if (row.is_cfg)
            begin
                settle_idle();
                set_reg(row.reg_idx, row.reg_val);
                cfg_we <= 1'b0;
            end
            else
                send_word(row.word, row.typed, row.known);
        end

        // random phases, each with a fresh set of every register
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_idle();
            for (int idx = 0; idx < 8; idx++)
                set_reg(CFG_IDX_W'(idx), pick_setting(CFG_IDX_W'(idx), ph));
            cfg_we <= 1'b0;
            run_random(PHASE_WORDS);
        end

        settle_idle();
        if (mismatch_count == 0)
            $display("[velocity_verlet_atom_update] OK");
        else
            $display("[velocity_verlet_atom_update] ERROR");
        $finish;
    end

endmodule
